// ===== rtl/tkst_pkg.sv =====
// tkst_pkg: shared types and constants for the top-k score table
// beat structs, request and reject codes, controller states and commands
// no dependencies
package tkst_pkg;

	localparam int TKST_DEPTH_DEF = 16;

	// request kinds
	localparam logic REQ_SUBMIT = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// reject reasons
	localparam logic [1:0] REJ_NONE = 2'd0;
	localparam logic [1:0] REJ_ZERO = 2'd1;
	localparam logic [1:0] REJ_DUP  = 2'd2;
	localparam logic [1:0] REJ_LOW  = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [63:0] new_score;
		logic [31:0] context_tag;
		logic [3:0]  read_index;
	} req_beat_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  reject_reason;
		logic [3:0]  insert_rank;
		logic [63:0] best_score;
		logic [4:0]  entry_count;
		logic        read_valid;
		logic [63:0] read_score;
		logic [31:0] read_tag;
	} rsp_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request beat
		logic cmp;     // register per-entry compare flags
		logic commit;  // apply table update and load response register
	} cmd_t;

endpackage

// ===== rtl/tkst_ctrl.sv =====
// tkst_ctrl: sequencing state machine of the top-k score table
// drives request stall, response valid and datapath commands
// depends on tkst_pkg
module tkst_ctrl import tkst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output cmd_t   cmd
);

	state_t state_q, state_nxt;
	logic   rsp_valid_q;
	logic   can_commit;

	assign can_commit = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (can_commit) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		cmd.load   = 1'b0;
		cmd.cmp    = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			ST_DONE: begin
				cmd.commit = can_commit;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== rtl/tkst_dpath.sv =====
// tkst_dpath: row of score/tag cells with local compare and shift
// plus request and response registers
// depends on tkst_pkg
module tkst_dpath import tkst_pkg::*; #(
	parameter int DEPTH = TKST_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  req_beat_t req,
	output rsp_beat_t rsp
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IXW = (IW > 4) ? IW : 4;

	req_beat_t   req_q;
	rsp_beat_t   rsp_q;
	logic [63:0] score_q [DEPTH];
	logic [31:0] tag_q   [DEPTH];
	logic [CW-1:0] count_q, count_nxt;
	logic [DEPTH-1:0] ge_q, dup_q;
	logic [DEPTH-1:0] ge_c, dup_c;

	logic          is_submit, full, do_ins;
	logic [1:0]    reason;
	logic [IW-1:0] rank;
	logic [63:0]   best;
	logic [IXW-1:0] idx_ext;
	logic [IW-1:0]  rd_addr;
	logic           rd_ok;

	// per-cell compare against the held request
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ge_c[i]  = (i < int'(count_q)) && (score_q[i] >= req_q.new_score);
			dup_c[i] = (i < int'(count_q)) && (score_q[i] == req_q.new_score)
				&& (tag_q[i] == req_q.context_tag);
		end
	end

	// ge flags form a prefix of ones, rank is the first zero
	always_comb begin
		rank = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!ge_q[i]) rank = IW'(i);
		end
	end

	assign is_submit = (req_q.req_type == REQ_SUBMIT);
	assign full      = (count_q == CW'(DEPTH));

	always_comb begin
		if (req_q.new_score == 64'd0) reason = REJ_ZERO;
		else if (|dup_q) reason = REJ_DUP;
		else if (full && ge_q[DEPTH-1]) reason = REJ_LOW;
		else reason = REJ_NONE;
	end

	assign do_ins    = is_submit && (reason == REJ_NONE);
	assign count_nxt = (do_ins && !full) ? count_q + CW'(1) : count_q;

	always_comb begin
		if (count_q == '0 && !do_ins) best = 64'd0;
		else if (do_ins && rank == '0) best = req_q.new_score;
		else best = score_q[0];
	end

	// read path, index is at most four bits wide
	assign idx_ext = IXW'(req_q.read_index);
	assign rd_addr = idx_ext[IW-1:0];
	assign rd_ok   = !is_submit && (int'(req_q.read_index) < int'(count_q))
		&& (int'(req_q.read_index) < DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.cmp) begin
			ge_q  <= ge_c;
			dup_q <= dup_c;
		end
		if (cmd.commit) begin
			rsp_q.accepted      <= do_ins;
			rsp_q.reject_reason <= is_submit ? reason : REJ_NONE;
			rsp_q.insert_rank   <= do_ins ? 4'(rank) : 4'd0;
			rsp_q.best_score    <= best;
			rsp_q.entry_count   <= 5'(count_nxt);
			rsp_q.read_valid    <= rd_ok;
			rsp_q.read_score    <= rd_ok ? score_q[rd_addr] : 64'd0;
			rsp_q.read_tag      <= rd_ok ? tag_q[rd_addr] : 32'd0;
		end
	end

	// each cell keeps, takes the new entry, or takes its upper neighbor
	always_ff @(posedge clk) begin
		if (cmd.commit && do_ins) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!ge_q[i]) begin
					if (i == 0) begin
						score_q[i] <= req_q.new_score;
						tag_q[i]   <= req_q.context_tag;
					end else if (ge_q[(i > 0) ? i - 1 : 0]) begin
						score_q[i] <= req_q.new_score;
						tag_q[i]   <= req_q.context_tag;
					end else begin
						score_q[i] <= score_q[(i > 0) ? i - 1 : 0];
						tag_q[i]   <= tag_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/top_k_score_table.sv =====
// top_k_score_table: bounded table of the highest scores in descending order
// instantiates tkst_ctrl and tkst_dpath, depends on tkst_pkg
//
// channel | signals                        | beat
// --------+--------------------------------+---------------------------
// request | req_valid, req_stall, req      | submit or read, req_beat_t
// response| rsp_valid, rsp_stall, rsp      | one result, rsp_beat_t
//
// each item passes through accept, per-cell compare and commit in turn
// the commit waits while an earlier result is held and stalled in the
// response register; a new request is taken as soon as the commit is done
// reset clears the entry count; cell contents stay undefined until written
// and are never seen, since only cells below the count are compared or read
module top_k_score_table import tkst_pkg::*; #(
	parameter int DEPTH = TKST_DEPTH_DEF  // table entries, 1 to 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	cmd_t cmd;

	// sequencing: stall, response valid, step commands
	tkst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// cells, compare flags, request and response registers
	tkst_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/tkst_chk.sv =====
// tkst_chk: port-level checks for the top-k score table
// bound to top_k_score_table, depends on tkst_pkg
module tkst_chk import tkst_pkg::*; #(
	parameter int DEPTH = TKST_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input req_beat_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp
);

	// held result does not change while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one item at a time: after an accepted beat the request side stalls
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while an item is in progress");

	// an accepted submit has no reject reason and no read data
	// a count of 32 or more wraps modulo 32 in the five-bit field
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |->
		rsp.reject_reason == REJ_NONE && !rsp.read_valid
		&& ((DEPTH > 31) || (rsp.entry_count != 5'd0)))
		else $error("accepted result carries reject or read fields");

	// count never exceeds the table depth when it fits the field
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH > 31) || (int'(rsp.entry_count) <= DEPTH))
		else $error("entry count above table depth");

endmodule

bind top_k_score_table tkst_chk #(.DEPTH(DEPTH)) u_tkst_chk (.*);
